// ===== hw/rtl/switch_bank_node_with_address_claim_top_macros.svh =====
// ----------------------------------------------------------------------------
// Switch bank node assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SWITCH_BANK_NODE_WITH_ADDRESS_CLAIM_TOP_MACROS_SVH
`define SWITCH_BANK_NODE_WITH_ADDRESS_CLAIM_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SBNAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBNAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sbnac_pkg.sv =====
// ----------------------------------------------------------------------------
// Switch bank node package
// Transaction types, configuration layout, codes and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbnac_pkg;

  // default sizes
  localparam int CHANNELS_DEF  = 8;
  localparam int MAX_RETRY_DEF = 8;

  // action codes of an input transaction
  localparam logic [1:0] ACT_FRAME  = 2'd0;
  localparam logic [1:0] ACT_POLL   = 2'd1;
  localparam logic [1:0] ACT_WINDOW = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  // link codes as reported on link_now
  localparam logic [1:0] LINK_IDLE    = 2'd0;
  localparam logic [1:0] LINK_CLAIMED = 2'd1;
  localparam logic [1:0] LINK_ACTIVE  = 2'd2;
  localparam logic [1:0] LINK_ABORT   = 2'd3;

  // configuration register indexes
  localparam int          CFG_IDX_W           = 3;
  localparam int          CFG_DATA_W          = 21;
  localparam logic [2:0]  CFG_IDENTITY        = 3'd0;
  localparam logic [2:0]  CFG_MANUFACTURER    = 3'd1;
  localparam logic [2:0]  CFG_DEV_FUNCTION    = 3'd2;
  localparam logic [2:0]  CFG_DEV_CLASS       = 3'd3;
  localparam logic [2:0]  CFG_SYS_INSTANCE    = 3'd4;
  localparam logic [2:0]  CFG_INDUSTRY_GROUP  = 3'd5;
  localparam logic [2:0]  CFG_BANK_ID         = 3'd6;
  localparam logic [2:0]  CFG_INITIAL_SENDER  = 3'd7;

  // register reset values
  localparam logic [20:0] IDENTITY_RST        = 21'd114351;
  localparam logic [10:0] MANUFACTURER_RST    = 11'd666;
  localparam logic [7:0]  DEV_FUNCTION_RST    = 8'd130;
  localparam logic [6:0]  DEV_CLASS_RST       = 7'd30;
  localparam logic [3:0]  SYS_INSTANCE_RST    = 4'd0;
  localparam logic [2:0]  INDUSTRY_GROUP_RST  = 3'd4;
  localparam logic [7:0]  BANK_ID_RST         = 8'd128;
  localparam logic [7:0]  INITIAL_SENDER_RST  = 8'd128;

  // protocol constants
  localparam logic [16:0] PGN_SWITCH_CTRL   = 17'd127502;
  localparam logic [16:0] PGN_SWITCH_STATUS = 17'd127501;
  localparam logic [16:0] PGN_CLAIM_BCAST   = 17'h0EEFF;
  localparam logic [16:0] PGN_GROUP_MASK    = 17'h1FE00;
  localparam logic [16:0] PGN_CLAIM_GROUP   = 17'h0EE00;
  localparam logic [16:0] PGN_REQUEST_GROUP = 17'h0EA00;
  localparam logic [23:0] REQ_CLAIM_PGN     = 24'h00EE00;
  localparam logic [7:0]  ADDR_GLOBAL       = 8'hFF;
  localparam logic [2:0]  PRIO_CLAIM        = 3'd6;
  localparam logic [2:0]  PRIO_STATUS       = 3'd3;
  localparam logic [3:0]  RETRY_SAT         = 4'd15;

  // one input transaction
  typedef struct packed {
    logic [1:0]  action;
    logic [28:0] can_id;
    logic [7:0]  rx_byte_0;
    logic [7:0]  rx_byte_1;
    logic [7:0]  rx_byte_2;
    logic [7:0]  rx_byte_3;
    logic [7:0]  rx_byte_4;
    logic [7:0]  rx_byte_5;
    logic [7:0]  rx_byte_6;
    logic [7:0]  rx_byte_7;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic        tx_valid;
    logic [28:0] tx_id;
    logic [7:0]  tx_byte_0;
    logic [7:0]  tx_byte_1;
    logic [7:0]  tx_byte_2;
    logic [7:0]  tx_byte_3;
    logic [7:0]  tx_byte_4;
    logic [7:0]  tx_byte_5;
    logic [7:0]  tx_byte_6;
    logic [7:0]  tx_byte_7;
    logic [7:0]  relay_outputs;
    logic [1:0]  link_now;
  } out_item_t;

  // configuration seen by the processing logic
  typedef struct packed {
    logic [20:0] identity_number;
    logic [10:0] manufacturer_code;
    logic [7:0]  device_function;
    logic [6:0]  device_class;
    logic [3:0]  system_instance;
    logic [2:0]  industry_group;
    logic [7:0]  bank_id;
  } cfg_regs_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbnac_cfg.sv =====
// ----------------------------------------------------------------------------
// Switch bank node configuration registers
// Write-only register file, each register truncated to its own width.
// ----------------------------------------------------------------------------
`default_nettype none

module sbnac_cfg
  import sbnac_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t                  cfg
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // decode one register write
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDENTITY:       regs_nxt.identity_number   = cfg_wdata[20:0];
        CFG_MANUFACTURER:   regs_nxt.manufacturer_code = cfg_wdata[10:0];
        CFG_DEV_FUNCTION:   regs_nxt.device_function   = cfg_wdata[7:0];
        CFG_DEV_CLASS:      regs_nxt.device_class      = cfg_wdata[6:0];
        CFG_SYS_INSTANCE:   regs_nxt.system_instance   = cfg_wdata[3:0];
        CFG_INDUSTRY_GROUP: regs_nxt.industry_group    = cfg_wdata[2:0];
        CFG_BANK_ID:        regs_nxt.bank_id           = cfg_wdata[7:0];
        // start address is only taken at reset, which restores its default
        CFG_INITIAL_SENDER: regs_nxt = regs_r;
        default:            regs_nxt = regs_r;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.identity_number   <= IDENTITY_RST;
      regs_r.manufacturer_code <= MANUFACTURER_RST;
      regs_r.device_function   <= DEV_FUNCTION_RST;
      regs_r.device_class      <= DEV_CLASS_RST;
      regs_r.system_instance   <= SYS_INSTANCE_RST;
      regs_r.industry_group    <= INDUSTRY_GROUP_RST;
      regs_r.bank_id           <= BANK_ID_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sbnac_core.sv =====
// ----------------------------------------------------------------------------
// Switch bank node processing core
// Link state, relay state and the combinational decode of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module sbnac_core
  import sbnac_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_RETRY = MAX_RETRY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  input  wire cfg_regs_t cfg,
  output out_item_t      result
);

  localparam logic [3:0] MaxRetryW = 4'(MAX_RETRY);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CLAIMED = 4'b0010,
    ST_ACTIVE  = 4'b0100,
    ST_ABORT   = 4'b1000
  } link_state_t;

  typedef enum logic [1:0] {
    TX_NONE,
    TX_CLAIM,
    TX_STATUS
  } tx_kind_t;

  link_state_t st_r, st_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [7:0]  sa_r, sa_nxt;
  logic [7:0]  inst_r, inst_nxt;
  logic [7:0]  relay_r, relay_nxt;

  logic [16:0] pgn;
  logic [7:0]  sender;
  logic [63:0] rx_name;
  logic [63:0] own_name;
  logic [63:0] claim_name;
  logic        name_gt;
  logic        name_eq;
  logic [3:0]  retry_inc;
  logic        ctrl_hit;
  logic        conflict_hit;
  logic        request_hit;
  logic [15:0] ctl_word;
  logic [7:0]  relay_upd;
  logic [15:0] status_word;
  logic [63:0] tx_word;
  logic [28:0] tx_id;
  tx_kind_t    kind;
  logic [1:0]  link_code;

  // field decode
  assign pgn      = item.can_id[24:8];
  assign sender   = item.can_id[7:0];
  assign rx_name  = {item.rx_byte_0, item.rx_byte_1, item.rx_byte_2, item.rx_byte_3,
                     item.rx_byte_4, item.rx_byte_5, item.rx_byte_6, item.rx_byte_7};
  assign ctl_word = {item.rx_byte_1, item.rx_byte_2};

  // own name with the current instance number, byte 0 most significant
  assign own_name = {cfg.identity_number[20:13], cfg.identity_number[12:5],
                     cfg.identity_number[4:0], cfg.manufacturer_code[10:8],
                     cfg.manufacturer_code[7:0], inst_r, cfg.device_function,
                     1'b0, cfg.device_class,
                     cfg.system_instance, cfg.industry_group, 1'b1};

  // byte-wise lexicographic order is the order of the packed words
  assign name_gt = rx_name > own_name;
  assign name_eq = rx_name == own_name;

  assign retry_inc = (retry_r == RETRY_SAT) ? RETRY_SAT : retry_r + 4'd1;

  // frame classification
  assign ctrl_hit     = (pgn == PGN_SWITCH_CTRL) && (item.rx_byte_0 == cfg.bank_id);
  assign conflict_hit = ((pgn & PGN_GROUP_MASK) == PGN_CLAIM_GROUP) && (sender == sa_r);
  assign request_hit  = ((pgn & PGN_GROUP_MASK) == PGN_REQUEST_GROUP)
                        && ((pgn[7:0] == sa_r) || (pgn[7:0] == ADDR_GLOBAL))
                        && ({item.rx_byte_0, item.rx_byte_1, item.rx_byte_2}
                            == REQ_CLAIM_PGN);

  // relay commands: 00 release, 01 set, others hold
  always_comb begin
    relay_upd = relay_r;
    for (int i = 0; i < 8; i++) begin
      if (i < CHANNELS) begin
        if (ctl_word[15-2*i -: 2] == 2'b00) begin
          relay_upd[i] = 1'b0;
        end else if (ctl_word[15-2*i -: 2] == 2'b01) begin
          relay_upd[i] = 1'b1;
        end
      end
    end
  end

  // link state machine and relay update
  always_comb begin
    st_nxt    = st_r;
    retry_nxt = retry_r;
    sa_nxt    = sa_r;
    inst_nxt  = inst_r;
    relay_nxt = relay_r;
    kind      = TX_NONE;
    if (st_r != ST_ABORT) begin
      case (item.action)
        ACT_POLL: begin
          if (st_r == ST_IDLE) begin
            if (retry_r > MaxRetryW) begin
              st_nxt = ST_ABORT;
            end else begin
              st_nxt = ST_CLAIMED;
              kind   = TX_CLAIM;
            end
          end
        end
        ACT_WINDOW: begin
          if (st_r == ST_CLAIMED) begin
            st_nxt    = ST_ACTIVE;
            retry_nxt = 4'd0;
          end
        end
        ACT_TICK: begin
          if (st_r == ST_ACTIVE) begin
            kind = TX_STATUS;
          end
        end
        ACT_FRAME: begin
          if (ctrl_hit) begin
            relay_nxt = relay_upd;
            kind      = TX_STATUS;
          end else if (conflict_hit) begin
            if ((st_r == ST_CLAIMED) ||
                ((st_r == ST_ACTIVE) && (!item.rx_byte_7[0] || name_gt))) begin
              // yield and move to a new address
              st_nxt    = ST_IDLE;
              retry_nxt = retry_inc;
              sa_nxt    = sa_r + {4'd0, retry_inc};
            end else if (st_r == ST_ACTIVE) begin
              // reclaim, bumping the instance on an identical name
              if (name_eq) begin
                inst_nxt = inst_r + 8'd1;
              end
              kind = TX_CLAIM;
            end
          end else if (request_hit) begin
            kind = TX_CLAIM;
          end
        end
        default: begin
          st_nxt = st_r;
        end
      endcase
    end
  end

  // claim name carries the instance number after this transaction
  assign claim_name = {own_name[63:32], inst_nxt, own_name[23:0]};

  // status bytes: relay i at bit 6-2*(i%4) of byte 1+i/4
  always_comb begin
    status_word = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < CHANNELS) begin
        status_word[14-2*i] = relay_nxt[i];
      end
    end
  end

  // transmit frame assembly
  always_comb begin
    case (kind)
      TX_CLAIM: begin
        tx_id   = {PRIO_CLAIM, 1'b0, PGN_CLAIM_BCAST, sa_r};
        tx_word = claim_name;
      end
      TX_STATUS: begin
        tx_id   = {PRIO_STATUS, 1'b0, PGN_SWITCH_STATUS, sa_r};
        tx_word = {cfg.bank_id, status_word, 40'd0};
      end
      default: begin
        tx_id   = '0;
        tx_word = '0;
      end
    endcase
  end

  // link code after this transaction
  always_comb begin
    case (st_nxt)
      ST_IDLE:    link_code = LINK_IDLE;
      ST_CLAIMED: link_code = LINK_CLAIMED;
      ST_ACTIVE:  link_code = LINK_ACTIVE;
      ST_ABORT:   link_code = LINK_ABORT;
      default:    link_code = LINK_IDLE;
    endcase
  end

  assign result.tx_valid      = (kind != TX_NONE);
  assign result.tx_id         = tx_id;
  assign result.tx_byte_0     = tx_word[63:56];
  assign result.tx_byte_1     = tx_word[55:48];
  assign result.tx_byte_2     = tx_word[47:40];
  assign result.tx_byte_3     = tx_word[39:32];
  assign result.tx_byte_4     = tx_word[31:24];
  assign result.tx_byte_5     = tx_word[23:16];
  assign result.tx_byte_6     = tx_word[15:8];
  assign result.tx_byte_7     = tx_word[7:0];
  assign result.relay_outputs = relay_nxt;
  assign result.link_now      = link_code;

  // node state, advanced once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      retry_r <= 4'd0;
      sa_r    <= INITIAL_SENDER_RST;
      inst_r  <= 8'd0;
      relay_r <= 8'd0;
    end else if (fire) begin
      st_r    <= st_nxt;
      retry_r <= retry_nxt;
      sa_r    <= sa_nxt;
      inst_r  <= inst_nxt;
      relay_r <= relay_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/switch_bank_node_with_address_claim_top.sv =====
// ----------------------------------------------------------------------------
// Switch bank node with address claim
// Relay bank controller with an address claim link state machine.
//
// Input channel (in_valid / in_stall / in_data): one received CAN frame or
// timing event per transaction. Result channel (out_valid / out_stall /
// out_data): exactly one result per input transaction, in order, holding
// the frame to send (tx_valid) plus relay and link status.
// Configuration: cfg_we writes cfg_wdata into register cfg_index; write
// it only while no transaction is in flight.
// From acceptance to result a transaction passes an input register, then
// one pass of decode, name compare and frame assembly into the result
// register. Throughput is one transaction per cycle, set by that one pass,
// while the result is not stalled. A stalled result holds; one more
// transaction may wait in the input register, after which in_stall rises.
// Reset clears both valid flags, idles the link with no retries, releases
// all relays and loads the default source address and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_bank_node_with_address_claim_top
  import sbnac_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_RETRY = MAX_RETRY_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "switch_bank_node_with_address_claim_top_macros.svh"

  cfg_regs_t cfg;
  in_item_t  in_data_r;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t result;
  logic      out_free;
  logic      fire;
  logic      in_take;
  logic      out_abort;
  logic      out_silent;

  // configuration registers
  sbnac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // processing core
  sbnac_core #(
    .CHANNELS  (CHANNELS),
    .MAX_RETRY (MAX_RETRY)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // handshake control
  assign out_free      = !out_valid_r || !out_stall;
  assign fire          = in_valid_r && out_free;
  assign in_stall      = in_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign in_valid_nxt  = in_stall ? in_valid_r : in_valid;
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result flags watched by the checks
  assign out_abort  = out_valid_r && (out_data_r.link_now == LINK_ABORT);
  assign out_silent = out_valid_r && !out_data_r.tx_valid;

  // checks
  `SBNAC_ASSERT_NEXT(a_abort_sticky, out_abort, !out_valid_r || out_abort, "abort left early")
  `SBNAC_ASSERT_SAME(a_abort_silent, out_abort, !out_data_r.tx_valid, "frame sent in abort")
  `SBNAC_ASSERT_SAME(a_idle_frame_zero, out_silent, out_data_r.tx_id == '0, "idle id not zero")
  `SBNAC_ASSERT_SAME(a_stall_needs_item, in_stall, in_valid_r && out_valid_r, "stall, none held")

endmodule

`default_nettype wire
